// ----- hdl/htfd_pkg.sv -----
// Shared types, constants and CRC function for the humidity/temperature frame decoder
`default_nettype none
package htfd_pkg;

  localparam int unsigned RAW_W    = 20;
  localparam int unsigned HUM_W    = 14;
  localparam int unsigned TEMP_W   = 15;
  localparam int unsigned HPROD_W  = RAW_W + HUM_W;
  localparam int unsigned TPROD_W  = RAW_W + TEMP_W;
  localparam int unsigned Q_DEPTH  = 2;

  localparam logic [7:0]        CRC_POLY    = 8'h31;
  localparam logic [7:0]        CRC_INIT    = 8'hFF;
  localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
  localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;

  // byte position within a frame: index of the next expected byte
  localparam logic [2:0] POS_IDLE     = 3'd0;
  localparam logic [2:0] POS_HUM_HI   = 3'd1;
  localparam logic [2:0] POS_HUM_MID  = 3'd2;
  localparam logic [2:0] POS_SHARED   = 3'd3;
  localparam logic [2:0] POS_TEMP_MID = 3'd4;
  localparam logic [2:0] POS_TEMP_LO  = 3'd5;
  localparam logic [2:0] POS_CRC      = 3'd6;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BUSY    = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } frame_status_t;

  typedef struct packed {
    frame_status_t    status;
    logic [RAW_W-1:0] hum_raw;
    logic [RAW_W-1:0] temp_raw;
  } job_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/htfd_front.sv -----
// Front end: byte acceptance, field assembly, CRC and frame status
`default_nettype none
module htfd_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata,
  input  wire logic                 rx_valid,
  input  wire logic                 rx_stall,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 frame_start,
  output logic                      push,
  output htfd_pkg::job_t            push_job
);

  logic                         crc_present;
  logic [2:0]                   byte_pos, byte_pos_next;
  logic [7:0]                   crc, crc_next;
  logic                         busy, busy_next;
  logic [htfd_pkg::RAW_W-1:0]   hum, hum_next;
  logic [htfd_pkg::RAW_W-1:0]   temp, temp_next;
  logic                         accept;
  htfd_pkg::frame_status_t      status;

  assign accept = rx_valid && !rx_stall;

  always_comb begin
    byte_pos_next = byte_pos;
    crc_next      = crc;
    busy_next     = busy;
    hum_next      = hum;
    temp_next     = temp;
    push          = 1'b0;
    status        = htfd_pkg::STATUS_OK;
    if (accept) begin
      if (frame_start) begin
        busy_next     = rx_byte[7];
        crc_next      = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, rx_byte);
        byte_pos_next = htfd_pkg::POS_HUM_HI;
      end else begin
        unique case (byte_pos)
          htfd_pkg::POS_HUM_HI: begin
            hum_next = {rx_byte, 12'h000};
          end
          htfd_pkg::POS_HUM_MID: begin
            hum_next = {hum[19:12], rx_byte, hum[3:0]};
          end
          htfd_pkg::POS_SHARED: begin
            hum_next  = {hum[19:4], rx_byte[7:4]};
            temp_next = {rx_byte[3:0], 16'h0000};
          end
          htfd_pkg::POS_TEMP_MID: begin
            temp_next = {temp[19:16], rx_byte, temp[7:0]};
          end
          htfd_pkg::POS_TEMP_LO: begin
            temp_next = {temp[19:8], rx_byte};
          end
          default: ;
        endcase
        priority if (byte_pos == htfd_pkg::POS_CRC) begin
          push          = 1'b1;
          status        = busy ? htfd_pkg::STATUS_BUSY :
                          (rx_byte != crc) ? htfd_pkg::STATUS_CRC_ERR : htfd_pkg::STATUS_OK;
          byte_pos_next = htfd_pkg::POS_IDLE;
        end else if (byte_pos == htfd_pkg::POS_IDLE || byte_pos > htfd_pkg::POS_CRC) begin
          byte_pos_next = htfd_pkg::POS_IDLE;
        end else begin
          crc_next = htfd_pkg::crc8_byte(crc, rx_byte);
          if (byte_pos == htfd_pkg::POS_TEMP_LO && !crc_present) begin
            push          = 1'b1;
            status        = busy ? htfd_pkg::STATUS_BUSY : htfd_pkg::STATUS_OK;
            byte_pos_next = htfd_pkg::POS_IDLE;
          end else begin
            byte_pos_next = byte_pos + 3'd1;
          end
        end
      end
    end
  end

  assign push_job.status   = status;
  assign push_job.hum_raw  = hum_next;
  assign push_job.temp_raw = temp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_present <= 1'b1;
      byte_pos    <= htfd_pkg::POS_IDLE;
      crc         <= htfd_pkg::CRC_INIT;
      busy        <= 1'b0;
      hum         <= '0;
      temp        <= '0;
    end else begin
      if (cfg_we) begin
        crc_present <= cfg_wdata;
      end
      byte_pos <= byte_pos_next;
      crc      <= crc_next;
      busy     <= busy_next;
      hum      <= hum_next;
      temp     <= temp_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/htfd_queue.sv -----
// Two-entry request queue between front end and scaling back end
`default_nettype none
module htfd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire htfd_pkg::job_t push_job,
  input  wire logic           pop,
  output htfd_pkg::job_t      pop_job,
  output logic                full,
  output logic                nonempty
);

  htfd_pkg::job_t mem [htfd_pkg::Q_DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = (count == 2'(htfd_pkg::Q_DEPTH));
  assign nonempty = (count != 2'd0);
  assign pop_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("request pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("request popped from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(htfd_pkg::Q_DEPTH))
    else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || full) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ----- hdl/htfd_back.sv -----
// Back end: fixed-point scaling pipeline and result register
`default_nettype none
module htfd_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         nonempty,
  input  wire htfd_pkg::job_t               pop_job,
  output logic                              pop,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic [1:0]                        frame_status,
  output logic [htfd_pkg::HUM_W-1:0]        humidity_centipercent,
  output logic signed [htfd_pkg::TEMP_W-1:0] temperature_centideg,
  output logic [htfd_pkg::RAW_W-1:0]        humidity_raw_out,
  output logic [htfd_pkg::RAW_W-1:0]        temperature_raw_out
);

  logic                           s1_valid;
  htfd_pkg::job_t                 s1_job;
  logic [htfd_pkg::HPROD_W-1:0]   s1_hprod;
  logic [htfd_pkg::TPROD_W-1:0]   s1_tprod;
  logic                           adv_out;
  logic                           adv_s1;
  logic [htfd_pkg::TEMP_W-1:0]    temp_scaled;

  assign adv_out = !res_valid || !res_stall;
  assign adv_s1  = !s1_valid || adv_out;
  assign pop     = nonempty && adv_s1;

  // raw value is 20 bits so it never exceeds full scale; no clamp needed
  assign temp_scaled = s1_tprod[htfd_pkg::TPROD_W-1:htfd_pkg::RAW_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid <= pop;
      end
      if (adv_out) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s1 && pop) begin
      s1_job   <= pop_job;
      s1_hprod <= {{htfd_pkg::HUM_W{1'b0}}, pop_job.hum_raw} *
                  {{htfd_pkg::RAW_W{1'b0}}, htfd_pkg::HUM_SCALE};
      s1_tprod <= {{htfd_pkg::TEMP_W{1'b0}}, pop_job.temp_raw} *
                  {{htfd_pkg::RAW_W{1'b0}}, htfd_pkg::TEMP_SCALE};
    end
    if (adv_out && s1_valid) begin
      frame_status          <= s1_job.status;
      humidity_centipercent <= s1_hprod[htfd_pkg::HPROD_W-1:htfd_pkg::RAW_W];
      temperature_centideg  <= $signed(temp_scaled - htfd_pkg::TEMP_OFFSET);
      humidity_raw_out      <= s1_job.hum_raw;
      temperature_raw_out   <= s1_job.temp_raw;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/humidity_temp_frame_decoder.sv -----
// A result passes from the request queue through the s1 product register to the result register.
// Throughput: one byte per cycle; a frame gives one result on its last byte.
// The front end stalls only when the two-entry request queue is full.
// Reset (rst, synchronous): frame closed, CRC at 0xFF, CRC check enabled,
// queue and result register empty.
`default_nettype none
module humidity_temp_frame_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_wdata,
  input  wire logic                         rx_valid,
  output logic                              rx_stall,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic                         frame_start,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic [1:0]                        frame_status,
  output logic [htfd_pkg::HUM_W-1:0]        humidity_centipercent,
  output logic signed [htfd_pkg::TEMP_W-1:0] temperature_centideg,
  output logic [htfd_pkg::RAW_W-1:0]        humidity_raw_out,
  output logic [htfd_pkg::RAW_W-1:0]        temperature_raw_out
);

  logic           push;
  htfd_pkg::job_t push_job;
  logic           pop;
  htfd_pkg::job_t pop_job;
  logic           full;
  logic           nonempty;

  assign rx_stall = full;

  htfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .push        (push),
    .push_job    (push_job)
  );

  htfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (full),
    .nonempty (nonempty)
  );

  htfd_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .nonempty              (nonempty),
    .pop_job               (pop_job),
    .pop                   (pop),
    .res_valid             (res_valid),
    .res_stall             (res_stall),
    .frame_status          (frame_status),
    .humidity_centipercent (humidity_centipercent),
    .temperature_centideg  (temperature_centideg),
    .humidity_raw_out      (humidity_raw_out),
    .temperature_raw_out   (temperature_raw_out)
  );

endmodule
`default_nettype wire
